[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared assertion forms for the checker modules of the project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_NOW(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");

// next-cycle implication, always checked
`define ASSERT_NEXT_ALWAYS(label, clk, a, c) \
  label: assert property (@(posedge clk) (a) |=> (c)) \
    else $error("assertion failed");

`endif

[rtl/aat_pkg.sv]
// ----------------------------------------------------------------------------
// Affine box transform package
// Widths, fixed-point types, register codes and reset values.
// ----------------------------------------------------------------------------
package aat_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int COEF_WIDTH  = 16;
  localparam int COEF_FRAC   = 12;
  localparam int AXES        = 3;
  localparam int PROD_W      = COORD_WIDTH + COEF_WIDTH;
  localparam int ACC_W       = PROD_W + 2;
  localparam int ROW_W       = AXES * COEF_WIDTH;
  localparam int CFG_W       = (ROW_W > COORD_WIDTH) ? ROW_W : COORD_WIDTH;
  localparam int CFG_IDX_W   = 3;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [COEF_WIDTH-1:0]  coef_t;
  typedef logic signed [PROD_W-1:0]      prod_t;
  typedef logic signed [ACC_W-1:0]       acc_t;
  typedef logic        [ROW_W-1:0]       row_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW_X   = 3'd0,
    REG_ROW_Y   = 3'd1,
    REG_ROW_Z   = 3'd2,
    REG_SHIFT_X = 3'd3,
    REG_SHIFT_Y = 3'd4,
    REG_SHIFT_Z = 3'd5
  } reg_index_t;

  localparam row_t ROW_X_RESET = row_t'(1) << (2 * COEF_WIDTH + COEF_FRAC);
  localparam row_t ROW_Y_RESET = row_t'(1) << (COEF_WIDTH + COEF_FRAC);
  localparam row_t ROW_Z_RESET = row_t'(1) << COEF_FRAC;

  localparam acc_t ROUND_BIAS = acc_t'(1) << (COEF_FRAC - 1);

  typedef struct packed {
    logic prod_en;
    logic bound_en;
    logic sum_en;
    logic out_en;
  } pipe_ctrl_t;

endpackage

[rtl/aat_box_in_if.sv]
// ----------------------------------------------------------------------------
// Input box channel
// Valid/ready channel carrying the lower and upper corners of a box.
// ----------------------------------------------------------------------------
interface aat_box_in_if;
  logic           valid;
  logic           ready;
  aat_pkg::coord_t box_min_x;
  aat_pkg::coord_t box_min_y;
  aat_pkg::coord_t box_min_z;
  aat_pkg::coord_t box_max_x;
  aat_pkg::coord_t box_max_y;
  aat_pkg::coord_t box_max_z;

  modport source (
    output valid, box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
    input  ready
  );
  modport sink (
    input  valid, box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
    output ready
  );
endinterface

[rtl/aat_box_out_if.sv]
// ----------------------------------------------------------------------------
// Output box channel
// Valid/ready channel carrying the bounds of a transformed box.
// ----------------------------------------------------------------------------
interface aat_box_out_if;
  logic           valid;
  logic           ready;
  aat_pkg::coord_t out_min_x;
  aat_pkg::coord_t out_min_y;
  aat_pkg::coord_t out_min_z;
  aat_pkg::coord_t out_max_x;
  aat_pkg::coord_t out_max_y;
  aat_pkg::coord_t out_max_z;

  modport source (
    output valid, out_min_x, out_min_y, out_min_z, out_max_x, out_max_y, out_max_z,
    input  ready
  );
  modport sink (
    input  valid, out_min_x, out_min_y, out_min_z, out_max_x, out_max_y, out_max_z,
    output ready
  );
endinterface

[rtl/aat_lane.sv]
// ----------------------------------------------------------------------------
// Transform lane
// One coefficient times both box extents on one axis, then the lesser and
// greater product.
// ----------------------------------------------------------------------------
module aat_lane (
  input  logic                clk,
  input  aat_pkg::pipe_ctrl_t ctrl,
  input  aat_pkg::coef_t      coef,
  input  aat_pkg::coord_t     lo,
  input  aat_pkg::coord_t     hi,
  output aat_pkg::prod_t      bound_lo,
  output aat_pkg::prod_t      bound_hi
);

  aat_pkg::prod_t prod_lo;
  aat_pkg::prod_t prod_hi;

  always_ff @(posedge clk) begin
    if (ctrl.prod_en) begin
      prod_lo <= aat_pkg::prod_t'(coef) * aat_pkg::prod_t'(lo);
      prod_hi <= aat_pkg::prod_t'(coef) * aat_pkg::prod_t'(hi);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.bound_en) begin
      if (prod_lo < prod_hi) begin
        bound_lo <= prod_lo;
        bound_hi <= prod_hi;
      end else begin
        bound_lo <= prod_hi;
        bound_hi <= prod_lo;
      end
    end
  end

endmodule

[rtl/aat_merge.sv]
// ----------------------------------------------------------------------------
// Axis merge
// Sums the lane bounds of one output axis with its translation, then rounds
// and saturates both sums to Q16.16.
// ----------------------------------------------------------------------------
module aat_merge (
  input  logic                clk,
  input  aat_pkg::pipe_ctrl_t ctrl,
  input  aat_pkg::prod_t      terms_lo [aat_pkg::AXES],
  input  aat_pkg::prod_t      terms_hi [aat_pkg::AXES],
  input  aat_pkg::coord_t     shift,
  output aat_pkg::coord_t     out_lo,
  output aat_pkg::coord_t     out_hi
);

  aat_pkg::acc_t sum_lo;
  aat_pkg::acc_t sum_hi;
  aat_pkg::acc_t base;
  aat_pkg::acc_t quot_lo;
  aat_pkg::acc_t quot_hi;

  function automatic aat_pkg::coord_t saturate(input aat_pkg::acc_t v);
    aat_pkg::acc_t lim_hi;
    aat_pkg::acc_t lim_lo;
    lim_hi = '0;
    lim_hi[aat_pkg::COORD_WIDTH-2:0] = '1;
    lim_lo = ~lim_hi;
    if (v > lim_hi) begin
      return aat_pkg::coord_t'(lim_hi[aat_pkg::COORD_WIDTH-1:0]);
    end else if (v < lim_lo) begin
      return aat_pkg::coord_t'(lim_lo[aat_pkg::COORD_WIDTH-1:0]);
    end
    return aat_pkg::coord_t'(v[aat_pkg::COORD_WIDTH-1:0]);
  endfunction

  assign base = (aat_pkg::acc_t'(shift) <<< aat_pkg::COEF_FRAC) + aat_pkg::ROUND_BIAS;

  always_ff @(posedge clk) begin
    if (ctrl.sum_en) begin
      sum_lo <= aat_pkg::acc_t'(terms_lo[0]) + aat_pkg::acc_t'(terms_lo[1])
              + aat_pkg::acc_t'(terms_lo[2]) + base;
      sum_hi <= aat_pkg::acc_t'(terms_hi[0]) + aat_pkg::acc_t'(terms_hi[1])
              + aat_pkg::acc_t'(terms_hi[2]) + base;
    end
  end

  assign quot_lo = sum_lo >>> aat_pkg::COEF_FRAC;
  assign quot_hi = sum_hi >>> aat_pkg::COEF_FRAC;

  always_ff @(posedge clk) begin
    if (ctrl.out_en) begin
      out_lo <= saturate(quot_lo);
      out_hi <= saturate(quot_hi);
    end
  end

endmodule

[rtl/affine_aabb_transform.sv]
// ----------------------------------------------------------------------------
// Affine bounding box transform
// Maps an axis-aligned box through a configured affine transform and returns
// the axis-aligned bound of the result.
// ----------------------------------------------------------------------------
// The block takes one box per clock cycle while box_in.ready is high; products,
// per-lane bounds, per-axis sums and rounding with saturation each hold one
// register stage. Nine lanes, one for each coefficient, each multiply both
// extents of their input axis in the same cycle, so the eighteen 16x32
// multipliers set the one-item-per-cycle rate; three merge units then add the
// lane bounds of each output axis. A stalled output fills the pipeline bubbles
// before the input stops. The user must write transform registers through the
// write port only while no box is in flight; the block does not enforce this.
// ----------------------------------------------------------------------------
module affine_aabb_transform (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   write_enable,
  input  logic [aat_pkg::CFG_IDX_W-1:0]          write_index,
  input  logic [aat_pkg::CFG_W-1:0]              write_data,
  aat_box_in_if.sink                             box_in,
  aat_box_out_if.source                          box_out
);

  localparam int STAGES = 4;

  aat_pkg::row_t       row_lin   [aat_pkg::AXES];
  aat_pkg::coord_t     shift_reg [aat_pkg::AXES];
  aat_pkg::coord_t     corner_lo [aat_pkg::AXES];
  aat_pkg::coord_t     corner_hi [aat_pkg::AXES];
  aat_pkg::prod_t      bound_lo  [aat_pkg::AXES][aat_pkg::AXES];
  aat_pkg::prod_t      bound_hi  [aat_pkg::AXES][aat_pkg::AXES];
  aat_pkg::coord_t     res_lo    [aat_pkg::AXES];
  aat_pkg::coord_t     res_hi    [aat_pkg::AXES];
  logic [STAGES-1:0]   stage_valid;
  logic [STAGES:0]     stage_ready;
  aat_pkg::pipe_ctrl_t ctrl;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_lin[0]   <= aat_pkg::ROW_X_RESET;
      row_lin[1]   <= aat_pkg::ROW_Y_RESET;
      row_lin[2]   <= aat_pkg::ROW_Z_RESET;
      shift_reg[0] <= '0;
      shift_reg[1] <= '0;
      shift_reg[2] <= '0;
    end else if (write_enable) begin
      unique case (aat_pkg::reg_index_t'(write_index))
        aat_pkg::REG_ROW_X:   row_lin[0]   <= write_data[aat_pkg::ROW_W-1:0];
        aat_pkg::REG_ROW_Y:   row_lin[1]   <= write_data[aat_pkg::ROW_W-1:0];
        aat_pkg::REG_ROW_Z:   row_lin[2]   <= write_data[aat_pkg::ROW_W-1:0];
        aat_pkg::REG_SHIFT_X: shift_reg[0] <= write_data[aat_pkg::COORD_WIDTH-1:0];
        aat_pkg::REG_SHIFT_Y: shift_reg[1] <= write_data[aat_pkg::COORD_WIDTH-1:0];
        aat_pkg::REG_SHIFT_Z: shift_reg[2] <= write_data[aat_pkg::COORD_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    stage_ready[STAGES] = box_out.ready;
    for (int s = STAGES - 1; s >= 0; s--) begin
      stage_ready[s] = !stage_valid[s] || stage_ready[s+1];
    end
  end

  assign ctrl.prod_en  = stage_ready[0];
  assign ctrl.bound_en = stage_ready[1];
  assign ctrl.sum_en   = stage_ready[2];
  assign ctrl.out_en   = stage_ready[3];

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
    end else begin
      if (stage_ready[0]) begin
        stage_valid[0] <= box_in.valid;
      end
      for (int s = 1; s < STAGES; s++) begin
        if (stage_ready[s]) begin
          stage_valid[s] <= stage_valid[s-1];
        end
      end
    end
  end

  assign box_in.ready = stage_ready[0];

  assign corner_lo[0] = box_in.box_min_x;
  assign corner_lo[1] = box_in.box_min_y;
  assign corner_lo[2] = box_in.box_min_z;
  assign corner_hi[0] = box_in.box_max_x;
  assign corner_hi[1] = box_in.box_max_y;
  assign corner_hi[2] = box_in.box_max_z;

  for (genvar r = 0; r < aat_pkg::AXES; r++) begin : g_row
    for (genvar k = 0; k < aat_pkg::AXES; k++) begin : g_lane
      aat_lane u_lane (
        .clk      (clk),
        .ctrl     (ctrl),
        .coef     (aat_pkg::coef_t'(
                     row_lin[r][(aat_pkg::AXES-1-k)*aat_pkg::COEF_WIDTH +: aat_pkg::COEF_WIDTH])),
        .lo       (corner_lo[k]),
        .hi       (corner_hi[k]),
        .bound_lo (bound_lo[r][k]),
        .bound_hi (bound_hi[r][k])
      );
    end

    aat_merge u_merge (
      .clk      (clk),
      .ctrl     (ctrl),
      .terms_lo (bound_lo[r]),
      .terms_hi (bound_hi[r]),
      .shift    (shift_reg[r]),
      .out_lo   (res_lo[r]),
      .out_hi   (res_hi[r])
    );
  end

  assign box_out.valid     = stage_valid[STAGES-1];
  assign box_out.out_min_x = res_lo[0];
  assign box_out.out_min_y = res_lo[1];
  assign box_out.out_min_z = res_lo[2];
  assign box_out.out_max_x = res_hi[0];
  assign box_out.out_max_y = res_hi[1];
  assign box_out.out_max_z = res_hi[2];

endmodule

[rtl/aat_checker.sv]
// ----------------------------------------------------------------------------
// Affine box transform checker
// Port-level checks on the box channels, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module aat_checker (
  input logic            clk,
  input logic            rst,
  input logic            in_valid,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input aat_pkg::coord_t out_min_x,
  input aat_pkg::coord_t out_min_y,
  input aat_pkg::coord_t out_min_z,
  input aat_pkg::coord_t out_max_x,
  input aat_pkg::coord_t out_max_y,
  input aat_pkg::coord_t out_max_z
);

  logic bounds_ordered;

  assign bounds_ordered = (out_min_x <= out_max_x) && (out_min_y <= out_max_y)
                       && (out_min_z <= out_max_z);

  `ASSERT_NOW(a_bounds_ordered, clk, rst, out_valid, bounds_ordered)
  `ASSERT_NOW(a_ready_when_drained, clk, rst, in_valid && !out_valid, in_ready)
  `ASSERT_NEXT(a_out_holds, clk, rst, out_valid && !out_ready, out_valid)
  `ASSERT_NEXT_ALWAYS(a_reset_clears, clk, rst, !out_valid)

endmodule

bind affine_aabb_transform aat_checker u_aat_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (box_in.valid),
  .in_ready  (box_in.ready),
  .out_valid (box_out.valid),
  .out_ready (box_out.ready),
  .out_min_x (box_out.out_min_x),
  .out_min_y (box_out.out_min_y),
  .out_min_z (box_out.out_min_z),
  .out_max_x (box_out.out_max_x),
  .out_max_y (box_out.out_max_y),
  .out_max_z (box_out.out_max_z)
);
